/* rtl/core/wed_pkg.sv */
package wed_pkg;

  localparam int unsigned COST_W = 11;
  localparam int unsigned WEIGHT_W = 4;
  localparam int unsigned SYM_W = 8;
  localparam int unsigned CMD_W = 2;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [COST_W-1:0] COST_LIMIT = 11'd2047;

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND_FIRST  = 2'd0,
    CMD_APPEND_SECOND = 2'd1,
    CMD_COMPUTE       = 2'd2,
    CMD_NOP           = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DELETION     = 2'd0,
    REG_INSERTION    = 2'd1,
    REG_SUBSTITUTION = 2'd2,
    REG_UNUSED       = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW_START,
    ST_ROW_LOAD,
    ST_CELL,
    ST_DONE
  } state_t;

  typedef logic [COST_W-1:0] cost_t;
  typedef logic [WEIGHT_W-1:0] weight_t;

  // Add a weight to a cost, clamp at the largest cost.
  function automatic cost_t sat_add(input cost_t a, input weight_t b);
    logic [COST_W:0] s;
    s = {1'b0, a} + {{(COST_W + 1 - WEIGHT_W){1'b0}}, b};
    return s[COST_W] ? COST_LIMIT : s[COST_W-1:0];
  endfunction

  function automatic cost_t min3(input cost_t a, input cost_t b, input cost_t c);
    cost_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

endpackage

/* rtl/core/wed_ram.sv */
module wed_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                         clk,
  input  logic                                         wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                             wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                             rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* rtl/core/weighted_edit_distance_top.sv */
// Channel   Handshake                    Payload
// -------   ---------------------------  ------------------------------------
// command   start & !busy                command[1:0], symbol[7:0]
// config    cfg_valid & cfg_ready        cfg_index[1:0], cfg_data[3:0]
// result    result_valid (one cycle)     distance[10:0], overflowed
//
// An append transaction leaves busy low. A compute transaction sweeps the
// matrix row by row, one matrix cell per cycle within a row, through the
// shared cell unit and the single read port of the cost row memory, with a
// row start and row load step between rows. busy stays high until the result
// strobe. rst is synchronous, clears lengths, overflow and control, and sets
// weights to 1, 1, 2; string and row memories hold garbage until written. The
// receiver cannot stall: result_valid is high for exactly one cycle per compute.
module weighted_edit_distance_top #(
  parameter int unsigned MAX_LEN = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [wed_pkg::CMD_W-1:0]  command,
  input  logic [wed_pkg::SYM_W-1:0]  symbol,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [wed_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [wed_pkg::WEIGHT_W-1:0]  cfg_data,
  output logic                       result_valid,
  output logic [wed_pkg::COST_W-1:0] distance,
  output logic                       overflowed
);

  import wed_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned LW = $clog2(MAX_LEN + 1);
  localparam logic [LW-1:0] LEN_FULL = LW'(MAX_LEN);
  localparam logic [LW-1:0] LEN_ONE = LW'(1);

  state_t state, state_next;

  // Configuration weights
  weight_t deletion_cost, insertion_cost, substitution_cost;

  // String bookkeeping
  logic [LW-1:0] first_length, second_length;
  logic          overflow_flag;

  // Sweep counters and cell operands
  logic [LW-1:0] row_count;   // rows of the second string done
  logic [LW-1:0] col_idx;     // current column, zero based
  cost_t         col0;        // left boundary of the current row
  cost_t         left;        // cell just computed in this row
  cost_t         diag;        // upper-left neighbor
  logic [SYM_W-1:0] row_sym;  // second-string byte of this row

  // Memory ports
  logic             first_we, second_we, row_we;
  logic [AW-1:0]    first_waddr, second_waddr, row_waddr;
  logic [AW-1:0]    first_raddr, second_raddr, row_raddr;
  logic [SYM_W-1:0] first_rdata, second_rdata;
  cost_t            row_wdata, row_rdata;

  // Shared cell unit
  cost_t   cell_value;
  weight_t sub_weight;

  logic accept;
  logic last_col;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign last_col  = ((col_idx + LEN_ONE) == first_length);

  // Pick the diagonal weight, then take the cheapest of the three moves.
  assign sub_weight = (first_rdata == row_sym) ? '0 : substitution_cost;
  assign cell_value = min3(sat_add(row_rdata, deletion_cost),
                           sat_add(left, insertion_cost),
                           sat_add(diag, sub_weight));

  wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_first_ram (
    .clk     (clk),
    .wr_en   (first_we),
    .wr_addr (first_waddr),
    .wr_data (symbol),
    .rd_addr (first_raddr),
    .rd_data (first_rdata)
  );

  wed_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_second_ram (
    .clk     (clk),
    .wr_en   (second_we),
    .wr_addr (second_waddr),
    .wr_data (symbol),
    .rd_addr (second_raddr),
    .rd_data (second_rdata)
  );

  // Row entry y of the recurrence lives at address y - 1; entry 0 is col0.
  wed_ram #(.WIDTH(COST_W), .DEPTH(MAX_LEN)) u_row_ram (
    .clk     (clk),
    .wr_en   (row_we),
    .wr_addr (row_waddr),
    .wr_data (row_wdata),
    .rd_addr (row_raddr),
    .rd_data (row_rdata)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept && (cmd_t'(command) == CMD_COMPUTE)) begin
          state_next = ST_INIT;
        end
      end
      ST_INIT: begin
        if (col_idx == first_length) begin
          state_next = ST_ROW_START;
        end
      end
      ST_ROW_START: begin
        state_next = (row_count == second_length) ? ST_DONE : ST_ROW_LOAD;
      end
      ST_ROW_LOAD: begin
        state_next = (first_length == '0) ? ST_ROW_START : ST_CELL;
      end
      ST_CELL: begin
        if (last_col) begin
          state_next = ST_ROW_START;
        end
      end
      ST_DONE: begin
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Memory controls
  always_comb begin
    first_we     = 1'b0;
    second_we    = 1'b0;
    row_we       = 1'b0;
    first_waddr  = first_length[AW-1:0];
    second_waddr = second_length[AW-1:0];
    row_waddr    = col_idx[AW-1:0];
    row_wdata    = cell_value;
    first_raddr  = '0;
    second_raddr = row_count[AW-1:0];
    row_raddr    = '0;
    unique case (state)
      ST_IDLE: begin
        // Append lands at the current length unless the string is full.
        if (accept) begin
          first_we  = (cmd_t'(command) == CMD_APPEND_FIRST) && (first_length != LEN_FULL);
          second_we = (cmd_t'(command) == CMD_APPEND_SECOND) &&
                      (second_length != LEN_FULL);
        end
      end
      ST_INIT: begin
        row_we    = (col_idx != first_length);
        row_wdata = sat_add(left, insertion_cost);
      end
      ST_CELL: begin
        row_we = 1'b1;
        // Fetch the next column while writing this one.
        if (!last_col) begin
          first_raddr = AW'(col_idx + LEN_ONE);
          row_raddr   = AW'(col_idx + LEN_ONE);
        end
      end
      ST_ROW_START, ST_ROW_LOAD, ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      deletion_cost     <= WEIGHT_W'(1);
      insertion_cost    <= WEIGHT_W'(1);
      substitution_cost <= WEIGHT_W'(2);
      first_length      <= '0;
      second_length     <= '0;
      overflow_flag     <= 1'b0;
      result_valid      <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= (state == ST_DONE);

      if (cfg_valid && cfg_ready) begin
        unique case (reg_idx_t'(cfg_index))
          REG_DELETION:     deletion_cost     <= cfg_data;
          REG_INSERTION:    insertion_cost    <= cfg_data;
          REG_SUBSTITUTION: substitution_cost <= cfg_data;
          REG_UNUSED: begin
          end
          default: begin
          end
        endcase
      end

      if (state == ST_IDLE && accept) begin
        unique case (cmd_t'(command))
          CMD_APPEND_FIRST: begin
            if (first_length != LEN_FULL) begin
              first_length <= first_length + LEN_ONE;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          CMD_APPEND_SECOND: begin
            if (second_length != LEN_FULL) begin
              second_length <= second_length + LEN_ONE;
            end else begin
              overflow_flag <= 1'b1;
            end
          end
          CMD_COMPUTE, CMD_NOP: begin
          end
          default: begin
          end
        endcase
      end

      // Clear the strings once the result goes out.
      if (state == ST_DONE) begin
        first_length  <= '0;
        second_length <= '0;
        overflow_flag <= 1'b0;
      end
    end
  end

  // Sweep datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        col_idx   <= '0;
        row_count <= '0;
        col0      <= '0;
        left      <= '0;
      end
      ST_INIT: begin
        // Build the top boundary row, one entry a cycle.
        if (col_idx != first_length) begin
          left    <= sat_add(left, insertion_cost);
          col_idx <= col_idx + LEN_ONE;
        end
      end
      ST_ROW_START: begin
      end
      ST_ROW_LOAD: begin
        row_sym <= second_rdata;
        diag    <= col0;
        col0    <= sat_add(col0, deletion_cost);
        left    <= sat_add(col0, deletion_cost);
        col_idx <= '0;
        if (first_length == '0) begin
          row_count <= row_count + LEN_ONE;
        end
      end
      ST_CELL: begin
        diag <= row_rdata;
        left <= cell_value;
        if (last_col) begin
          row_count <= row_count + LEN_ONE;
        end else begin
          col_idx <= col_idx + LEN_ONE;
        end
      end
      ST_DONE: begin
        // The last cell of the last row is the distance.
        distance   <= left;
        overflowed <= overflow_flag;
      end
      default: begin
      end
    endcase
  end

endmodule
